[rtl/core/ils_pkg.sv]
package ils_pkg;

   localparam int CAPACITY_DEF = 256;
   localparam int POS_W        = 9;
   localparam int FIDX_W       = 8;
   localparam int LCNT_W       = 9;
   localparam int REQ_W        = 3;
   localparam int DATA_W       = 32;

   typedef logic [REQ_W-1:0]         req_code_type;
   typedef logic [POS_W-1:0]         pos_type;
   typedef logic signed [DATA_W-1:0] data_type;

   // request codes
   localparam req_code_type REQ_APPEND = 3'd0;
   localparam req_code_type REQ_INSERT = 3'd1;
   localparam req_code_type REQ_SET    = 3'd2;
   localparam req_code_type REQ_REMOVE = 3'd3;
   localparam req_code_type REQ_GET    = 3'd4;
   localparam req_code_type REQ_FIND   = 3'd5;
   localparam req_code_type REQ_CLEAR  = 3'd6;

   // finished result handed from the sequencer to the output register
   typedef struct packed {
      logic              ok;
      data_type          read_value;
      logic [FIDX_W-1:0] found_index;
      logic [LCNT_W-1:0] list_count;
      logic              is_empty;
      data_type          front_value;
      data_type          back_value;
   } rslt_type;

endpackage

[rtl/core/ils_store.sv]
module ils_store #(
   parameter int DEPTH = ils_pkg::CAPACITY_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  ils_pkg::data_type wr_data,
   input  logic [AW-1:0]    rd_addr,
   output ils_pkg::data_type rd_data
);
   import ils_pkg::*;

   data_type mem [DEPTH];
   data_type rd_data_ff;

   // one write port, one read port, read data registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/ils_seq.sv]
module ils_seq #(
   parameter int CAPACITY = ils_pkg::CAPACITY_DEF,
   parameter int AW       = $clog2(CAPACITY),
   parameter int CW       = $clog2(CAPACITY + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  ils_pkg::req_code_type req_type,
   input  ils_pkg::pos_type      req_position,
   input  ils_pkg::data_type     req_item_value,
   output logic                  res_valid,
   input  logic                  res_take,
   output ils_pkg::rslt_type     res,
   output logic                  wr_en,
   output logic [AW-1:0]         wr_addr,
   output ils_pkg::data_type     wr_data,
   output logic [AW-1:0]         rd_addr,
   input  ils_pkg::data_type     rd_data
);
   import ils_pkg::*;

   localparam int XW = (CW > POS_W) ? CW : POS_W;

   typedef enum logic [3:0] {
      ST_IDLE, ST_UP, ST_DN, ST_GET_RD, ST_GET_CAP, ST_SCAN,
      ST_FIN0, ST_FIN1, ST_FIN2, ST_OUT
   } state_type;

   state_type         state_ff;
   logic [CW-1:0]     count_ff;
   logic [CW-1:0]     idx_ff;
   logic [CW-1:0]     pdst_ff;   // address tied to the read in flight
   logic [CW-1:0]     pos_ff;
   logic              pend_ff;   // a read issued last cycle is due
   logic              cap_ff;    // first read of a remove is the taken value
   data_type          val_ff;
   logic              ok_ff;
   data_type          rd_ff;
   logic [FIDX_W-1:0] fidx_ff;
   data_type          front_ff;
   data_type          back_ff;

   logic [XW-1:0] pos_x;
   logic [XW-1:0] cnt_x;
   logic          full;
   logic          pos_lt;
   logic          pos_le;
   logic          ins_ok;
   logic [CW-1:0] idx_m1;
   logic [CW-1:0] cnt_m1;
   logic          is_empty;

   assign pos_x    = XW'(req_position);
   assign cnt_x    = XW'(count_ff);
   assign full     = (count_ff == CW'(CAPACITY));
   assign pos_lt   = (pos_x < cnt_x);
   assign pos_le   = (pos_x <= cnt_x);
   assign ins_ok   = !full && pos_le;
   assign idx_m1   = idx_ff - 1'b1;
   assign cnt_m1   = count_ff - 1'b1;
   assign is_empty = (count_ff == '0);

   assign req_ready = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_OUT);

   assign res.ok          = ok_ff;
   assign res.read_value  = rd_ff;
   assign res.found_index = fidx_ff;
   assign res.list_count  = LCNT_W'(count_ff);
   assign res.is_empty    = is_empty;
   assign res.front_value = is_empty ? '0 : front_ff;
   assign res.back_value  = is_empty ? '0 : back_ff;

   // memory port control
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = '0;
      rd_addr = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_type)
                  REQ_APPEND: begin
                     if (!full) begin
                        wr_en   = 1'b1;
                        wr_addr = count_ff[AW-1:0];
                        wr_data = req_item_value;
                     end
                  end
                  REQ_SET: begin
                     if (pos_lt) begin
                        wr_en   = 1'b1;
                        wr_addr = AW'(req_position);
                        wr_data = req_item_value;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_UP: begin
            rd_addr = idx_m1[AW-1:0];
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = pdst_ff[AW-1:0];
               wr_data = rd_data;
            end else if (idx_ff <= pos_ff) begin
               wr_en   = 1'b1;
               wr_addr = pos_ff[AW-1:0];
               wr_data = val_ff;
            end
         end
         ST_DN: begin
            rd_addr = idx_ff[AW-1:0];
            if (pend_ff && !cap_ff) begin
               wr_en   = 1'b1;
               wr_addr = pdst_ff[AW-1:0];
               wr_data = rd_data;
            end
         end
         ST_GET_RD: rd_addr = pos_ff[AW-1:0];
         ST_SCAN:   rd_addr = idx_ff[AW-1:0];
         ST_FIN1:   rd_addr = cnt_m1[AW-1:0];
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  rd_ff   <= '0;
                  fidx_ff <= '0;
                  pend_ff <= 1'b0;
                  cap_ff  <= 1'b1;
                  val_ff  <= req_item_value;
                  pos_ff  <= CW'(req_position);
                  case (req_type)
                     REQ_APPEND: begin
                        ok_ff    <= !full;
                        state_ff <= ST_FIN0;
                        if (!full) begin
                           count_ff <= count_ff + 1'b1;
                        end
                     end
                     REQ_INSERT: begin
                        ok_ff    <= ins_ok;
                        idx_ff   <= count_ff;
                        state_ff <= ins_ok ? ST_UP : ST_FIN0;
                     end
                     REQ_SET: begin
                        ok_ff    <= pos_lt;
                        state_ff <= ST_FIN0;
                     end
                     REQ_REMOVE: begin
                        ok_ff    <= pos_lt;
                        idx_ff   <= CW'(req_position);
                        state_ff <= pos_lt ? ST_DN : ST_FIN0;
                     end
                     REQ_GET: begin
                        ok_ff    <= pos_lt;
                        state_ff <= pos_lt ? ST_GET_RD : ST_FIN0;
                     end
                     REQ_FIND: begin
                        ok_ff    <= 1'b0;
                        idx_ff   <= '0;
                        state_ff <= ST_SCAN;
                     end
                     REQ_CLEAR: begin
                        count_ff <= '0;
                        ok_ff    <= 1'b1;
                        state_ff <= ST_FIN0;
                     end
                     default: begin
                        ok_ff    <= 1'b0;
                        state_ff <= ST_FIN0;
                     end
                  endcase
               end
            end
            // insert: move entries up from the tail, then drop the value in
            ST_UP: begin
               if (idx_ff > pos_ff) begin
                  pdst_ff <= idx_ff;
                  idx_ff  <= idx_m1;
                  pend_ff <= 1'b1;
               end else begin
                  pend_ff <= 1'b0;
                  if (!pend_ff) begin
                     count_ff <= count_ff + 1'b1;
                     state_ff <= ST_FIN0;
                  end
               end
            end
            // remove: first read is the taken value, rest move down by one
            ST_DN: begin
               if (pend_ff && cap_ff) begin
                  rd_ff  <= rd_data;
                  cap_ff <= 1'b0;
               end
               if (idx_ff < count_ff) begin
                  pdst_ff <= idx_m1;
                  idx_ff  <= idx_ff + 1'b1;
                  pend_ff <= 1'b1;
               end else begin
                  pend_ff <= 1'b0;
                  if (!pend_ff) begin
                     count_ff <= cnt_m1;
                     state_ff <= ST_FIN0;
                  end
               end
            end
            ST_GET_RD: state_ff <= ST_GET_CAP;
            ST_GET_CAP: begin
               rd_ff    <= rd_data;
               state_ff <= ST_FIN0;
            end
            // find: one compare per cycle against the entry read last cycle
            ST_SCAN: begin
               if (pend_ff && (rd_data == val_ff)) begin
                  ok_ff    <= 1'b1;
                  fidx_ff  <= FIDX_W'(pdst_ff);
                  pend_ff  <= 1'b0;
                  state_ff <= ST_FIN0;
               end else if (idx_ff < count_ff) begin
                  pdst_ff <= idx_ff;
                  idx_ff  <= idx_ff + 1'b1;
                  pend_ff <= 1'b1;
               end else begin
                  pend_ff <= 1'b0;
                  if (!pend_ff) begin
                     state_ff <= ST_FIN0;
                  end
               end
            end
            ST_FIN0: state_ff <= ST_FIN1;
            ST_FIN1: begin
               front_ff <= rd_data;
               state_ff <= ST_FIN2;
            end
            ST_FIN2: begin
               back_ff  <= rd_data;
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (res_take) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (CW'(wr_addr) <= count_ff))
      else $error("write beyond list tail");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      res_valid && !res_take |=> res_valid && $stable(count_ff))
      else $error("result dropped before taken");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) && req_valid && (req_type == REQ_CLEAR) |=> count_ff == '0)
      else $error("clear left entries");

endmodule

[rtl/core/indexed_list_store_core.sv]
// Insert, remove and find walk the store one entry per cycle; append, set, get, clear and
//   failed requests do not walk. Every request then reads the front and back entries
//   before its result is loaded into the result register.
// Throughput: one request at a time; the next is taken the cycle after the result is registered.
// Reset: synchronous, active high; clears the entry count and control state.
//   Entry memory is not cleared: entries at or beyond the count never reach a result.
module indexed_list_store_core #(
   parameter int CAPACITY = ils_pkg::CAPACITY_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  ils_pkg::req_code_type req_type,
   input  ils_pkg::pos_type      req_position,
   input  ils_pkg::data_type     req_item_value,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_ok,
   output ils_pkg::data_type     rsp_read_value,
   output logic [7:0]            rsp_found_index,
   output logic [8:0]            rsp_list_count,
   output logic                  rsp_is_empty,
   output ils_pkg::data_type     rsp_front_value,
   output ils_pkg::data_type     rsp_back_value
);
   import ils_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   // memory port between sequencer and entry store
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   data_type      wr_data;
   logic [AW-1:0] rd_addr;
   data_type      rd_data;

   // finished result from the sequencer
   logic     res_valid;
   logic     res_take;
   rslt_type res;

   // response output register
   logic     rsp_valid_ff;
   rslt_type rsp_ff;

   ils_store #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // sequencer: at most one compare/shift walk over the store per request
   ils_seq #(
      .CAPACITY (CAPACITY),
      .AW       (AW),
      .CW       (CW)
   ) u_seq (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_position   (req_position),
      .req_item_value (req_item_value),
      .res_valid      (res_valid),
      .res_take       (res_take),
      .res,
      .wr_en          (wr_en),
      .wr_addr        (wr_addr),
      .wr_data        (wr_data),
      .rd_addr        (rd_addr),
      .rd_data        (rd_data)
   );

   // the register takes a new result when empty or being drained this cycle
   assign res_take = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         if (res_valid && res_take) begin
            rsp_valid_ff <= 1'b1;
            rsp_ff       <= res;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_ff.ok;
   assign rsp_read_value  = rsp_ff.read_value;
   assign rsp_found_index = rsp_ff.found_index;
   assign rsp_list_count  = rsp_ff.list_count;
   assign rsp_is_empty    = rsp_ff.is_empty;
   assign rsp_front_value = rsp_ff.front_value;
   assign rsp_back_value  = rsp_ff.back_value;

endmodule

[dv/indexed_list_store_core_tb.sv]
module indexed_list_store_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ils_pkg::*;

   localparam int LIST_CAP       = CAPACITY_DEF;
   // worst correct run: ~2300 requests, each a full-list walk plus the longest sender
   // gap and receiver stall; the limit is set well above that
   localparam int CYCLE_LIMIT    = 4_000_000;
   // longest request walks the whole store; the settle wait leaves margin beyond that
   localparam int SETTLE_CYCLES  = 300;
   localparam int HOLD_CYCLES    = 600;
   localparam int MAX_REPORTS    = 10;
   localparam int RANDOM_COUNT   = 2000;
   // the one request code the block does not define
   localparam req_code_type REQ_UNUSED = 3'd7;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_code_type req_type = REQ_APPEND;
   pos_type      req_position = '0;
   data_type     req_item_value = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   logic         rsp_ok;
   data_type     rsp_read_value;
   logic [7:0]   rsp_found_index;
   logic [8:0]   rsp_list_count;
   logic         rsp_is_empty;
   data_type     rsp_front_value;
   data_type     rsp_back_value;

   // predicted list contents, updated as each request is accepted
   data_type     list_q[$];
   // results still owed by the block, oldest first
   rslt_type     pending_results[$];

   int           error_count = 0;
   int           result_count = 0;
   int           cycle_count = 0;
   // random idling on both sides; off for stretches of back-to-back traffic
   bit           idle_on = 1'b1;
   // long receiver hold-off requested by the pressure test
   int           hold_request = 0;

   indexed_list_store_core #(
      .CAPACITY(LIST_CAP)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_position   (req_position),
      .req_item_value (req_item_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_ok         (rsp_ok),
      .rsp_read_value (rsp_read_value),
      .rsp_found_index(rsp_found_index),
      .rsp_list_count (rsp_list_count),
      .rsp_is_empty   (rsp_is_empty),
      .rsp_front_value(rsp_front_value),
      .rsp_back_value (rsp_back_value)
   );

   initial begin
      forever begin
         #2 clock = ~clock;
      end
   end

   // Watchdog: a hung handshake or a lost result ends the run here.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL");
      $finish;
   end

   // Stall length: mostly short, now and then a long one.
   function automatic int stall_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return $urandom_range(1, 3);
      else if (r < 95)
         return $urandom_range(4, 12);
      else
         return $urandom_range(30, 80);
   endfunction

   // Predict one request against the list model; returns the result the block owes.
   function automatic rslt_type apply_list_request(req_code_type code, pos_type pos,
                                                   data_type value);
      rslt_type r;
      int       fill;
      r    = '0;
      fill = list_q.size();
      case (code)
         REQ_APPEND: begin
            if (fill < LIST_CAP) begin
               list_q.insert(fill, value);
               r.ok = 1'b1;
            end
         end
         REQ_INSERT: begin
            // insert at count is a legal append at the back
            if (fill < LIST_CAP && int'(pos) <= fill) begin
               list_q.insert(int'(pos), value);
               r.ok = 1'b1;
            end
         end
         REQ_SET: begin
            if (int'(pos) < fill) begin
               list_q[pos] = value;
               r.ok = 1'b1;
            end
         end
         REQ_REMOVE: begin
            if (int'(pos) < fill) begin
               r.read_value = list_q[pos];
               list_q.delete(int'(pos));
               r.ok = 1'b1;
            end
         end
         REQ_GET: begin
            if (int'(pos) < fill) begin
               r.read_value = list_q[pos];
               r.ok = 1'b1;
            end
         end
         REQ_FIND: begin
            // first match wins; a miss reports index zero
            for (int k = 0; k < fill; k++) begin
               if (list_q[k] == value) begin
                  r.found_index = k[FIDX_W-1:0];
                  r.ok = 1'b1;
                  break;
               end
            end
         end
         REQ_CLEAR: begin
            list_q.delete();
            r.ok = 1'b1;
         end
         default: begin
            // unused code: ignored, still answered with ok low
         end
      endcase
      fill          = list_q.size();
      r.list_count  = fill[LCNT_W-1:0];
      r.is_empty    = (fill == 0);
      r.front_value = (fill > 0) ? list_q[0] : '0;
      r.back_value  = (fill > 0) ? list_q[fill-1] : '0;
      return r;
   endfunction

   // Offer one request and wait for the handshake. Valid is left high after
   // acceptance; the next call either replaces the payload or drops valid at
   // the following falling edge, so no edge can take the same request twice.
   task automatic send_request(req_code_type code, pos_type pos, data_type value);
      int gap;
      gap = 0;
      if (idle_on && $urandom_range(0, 99) < 40)
         gap = stall_length();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid      <= 1'b1;
      req_type       <= code;
      req_position   <= pos;
      req_item_value <= value;
      do
         @(posedge clock);
      while (!req_ready);
      pending_results.insert(pending_results.size(), apply_list_request(code, pos, value));
   endtask

   task automatic note_error(string what, logic [31:0] want, logic [31:0] got);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("result %0d: %s expected %h got %h", result_count, what, want, got);
   endtask

   // Receiver: random stalls, plus the long hold-off that the pressure test asks
   // for, counted down here cycle by cycle.
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (hold_request > 0) begin
            rsp_ready <= 1'b0;
            stall_left = hold_request - 1;
            hold_request = 0;
         end else if (idle_on && $urandom_range(0, 99) < 20) begin
            rsp_ready <= 1'b0;
            stall_left = stall_length() - 1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Result checker: every accepted result is matched against the oldest
   // prediction, field by field.
   always @(posedge clock) begin
      rslt_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            note_error("result with no request pending, list_count", '0, rsp_list_count);
         end else begin
            want = pending_results.pop_front();
            if (rsp_ok !== want.ok)
               note_error("ok", want.ok, rsp_ok);
            if (rsp_read_value !== want.read_value)
               note_error("read_value", want.read_value, rsp_read_value);
            if (rsp_found_index !== want.found_index)
               note_error("found_index", want.found_index, rsp_found_index);
            if (rsp_list_count !== want.list_count)
               note_error("list_count", want.list_count, rsp_list_count);
            if (rsp_is_empty !== want.is_empty)
               note_error("is_empty", want.is_empty, rsp_is_empty);
            if (rsp_front_value !== want.front_value)
               note_error("front_value", want.front_value, rsp_front_value);
            if (rsp_back_value !== want.back_value)
               note_error("back_value", want.back_value, rsp_back_value);
         end
         result_count++;
      end
   end

   // Every request kind on a short list, failures on the empty list, the
   // extreme values and positions with the top bit set.
   task automatic test_basic_requests();
      send_request(REQ_GET,    9'd0,   32'sd5);
      send_request(REQ_REMOVE, 9'd0,   32'sd5);
      send_request(REQ_FIND,   9'd0,   32'sd0);
      send_request(REQ_SET,    9'd0,   32'sd9);
      send_request(REQ_INSERT, 9'd1,   32'sd9);       // beyond count on empty list
      send_request(REQ_INSERT, 9'd0,   32'sd17);
      send_request(REQ_APPEND, 9'd0,   32'sh8000_0000);
      send_request(REQ_APPEND, 9'd511, 32'sh7fff_ffff);
      send_request(REQ_APPEND, 9'd0,   32'sd0);
      send_request(REQ_INSERT, 9'd1,   -32'sd1);
      send_request(REQ_INSERT, 9'd5,   32'sd42);      // at count: lands at the back
      send_request(REQ_GET,    9'd511, 32'sd0);
      send_request(REQ_SET,    9'd2,   32'sh5555_5555);
      send_request(REQ_FIND,   9'd0,   32'sh7fff_ffff);
      send_request(REQ_FIND,   9'd0,   32'sd12345);    // miss
      send_request(REQ_REMOVE, 9'd0,   32'sd0);
      send_request(REQ_REMOVE, 9'd4,   32'sd0);        // last entry
      send_request(REQ_REMOVE, 9'd4,   32'sd0);        // at count: fails
      send_request(REQ_UNUSED, 9'd511, 32'shffff_ffff);
      send_request(REQ_SET,    9'd0,   32'shaaaa_aaaa);
      send_request(REQ_GET,    9'd0,   32'sd0);
      send_request(REQ_CLEAR,  9'd0,   32'sd0);
      send_request(REQ_GET,    9'd0,   32'sd0);
      send_request(REQ_APPEND, 9'd256, 32'sd3);
   endtask

   // Fill to capacity back to back: full-list failures, last index, refill.
   task automatic test_full_list();
      idle_on = 1'b0;
      send_request(REQ_CLEAR, 9'd0, 32'sd0);
      for (int k = 0; k < LIST_CAP; k++)
         send_request(REQ_APPEND, pos_type'($urandom_range(0, 511)), data_type'($urandom));
      send_request(REQ_APPEND, 9'd0,   32'sd1);
      send_request(REQ_INSERT, 9'd0,   32'sd1);
      send_request(REQ_INSERT, 9'd256, 32'sd1);
      send_request(REQ_GET,    9'd255, 32'sd0);
      send_request(REQ_FIND,   9'd0,   list_q[LIST_CAP-1]);
      send_request(REQ_SET,    9'd255, 32'sh0f0f_0f0f);
      send_request(REQ_GET,    9'd256, 32'sd0);
      send_request(REQ_REMOVE, 9'd0,   32'sd0);
      send_request(REQ_INSERT, 9'd0,   32'sh7fff_ffff); // full again
      send_request(REQ_INSERT, 9'd255, 32'sd2);
      send_request(REQ_REMOVE, 9'd255, 32'sd0);
      send_request(REQ_INSERT, 9'd255, 32'sd2);
      send_request(REQ_FIND,   9'd0,   32'sd2);
      send_request(REQ_CLEAR,  9'd0,   32'sd0);
      idle_on = 1'b1;
   endtask

   // Receiver holds off for a long stretch while requests keep coming, so the
   // result register stays full and the block stops taking requests.
   task automatic test_output_stall();
      idle_on = 1'b0;
      hold_request = HOLD_CYCLES;
      for (int k = 0; k < 16; k++)
         send_request((k % 3 == 0) ? REQ_INSERT : REQ_APPEND, 9'd0, data_type'($urandom));
      idle_on = 1'b1;
   endtask

   // Random traffic in phases that grow, churn or shrink the list, with values
   // drawn often from the list itself so that finds hit.
   task automatic test_random_traffic(int count);
      int           mode;
      int           grow_w;
      int           shrink_w;
      int           fill;
      int           r;
      req_code_type code;
      pos_type      pos;
      data_type     value;
      mode = 0;
      for (int k = 0; k < count; k++) begin
         if (k % 100 == 0)
            mode = $urandom_range(0, 2);
         idle_on  = ((k / 250) % 4) != 3;
         grow_w   = (mode == 0) ? 50 : (mode == 1) ? 30 : 10;
         shrink_w = (mode == 2) ? 50 : (mode == 1) ? 30 : 10;
         fill     = list_q.size();

         r = $urandom_range(0, 99);
         if (r == 0)
            code = REQ_CLEAR;
         else if (r == 1)
            code = REQ_UNUSED;
         else if (r < 2 + grow_w)
            code = $urandom_range(0, 1) ? REQ_APPEND : REQ_INSERT;
         else if (r < 2 + grow_w + shrink_w)
            code = REQ_REMOVE;
         else begin
            case ($urandom_range(0, 2))
               0:       code = REQ_SET;
               1:       code = REQ_GET;
               default: code = REQ_FIND;
            endcase
         end

         r = $urandom_range(0, 99);
         if (r < 85) begin
            if (code == REQ_INSERT)
               pos = pos_type'($urandom_range(0, fill));
            else
               pos = (fill == 0) ? '0 : pos_type'($urandom_range(0, fill - 1));
         end else if (r < 95) begin
            case ($urandom_range(0, 2))
               0:       pos = '0;
               1:       pos = pos_type'(fill);
               default: pos = (fill == 0) ? '0 : pos_type'(fill - 1);
            endcase
         end else begin
            pos = pos_type'($urandom_range(0, 511));
         end

         r = $urandom_range(0, 99);
         if (code == REQ_FIND && fill > 0 && r < 60)
            value = list_q[$urandom_range(0, fill - 1)];
         else if (r < 30)
            value = data_type'($urandom_range(0, 8)) - 32'sd4;
         else if (r < 45 && fill > 0)
            value = list_q[$urandom_range(0, fill - 1)];
         else if (r < 55) begin
            case ($urandom_range(0, 3))
               0:       value = 32'sh8000_0000;
               1:       value = 32'sh7fff_ffff;
               2:       value = -32'sd1;
               default: value = '0;
            endcase
         end else
            value = data_type'($urandom);

         send_request(code, pos, value);
      end
      idle_on = 1'b1;
   endtask

   initial begin
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      test_basic_requests();
      test_output_stall();
      test_full_list();
      test_random_traffic(RANDOM_COUNT);

      // stop offering, then let every owed result come back
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      // a stray extra result would show up within one full walk
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (error_count == 0 && pending_results.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
